/* rtl/core/learning_switch_mac_table_top_defines.svh */
// Assertion macros shared by the checker of the learning switch address table.
// No dependencies; guarded against double inclusion.
`ifndef LEARNING_SWITCH_MAC_TABLE_TOP_DEFINES_SVH
`define LEARNING_SWITCH_MAC_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/core/lsmt_pkg.sv */
// Package of the learning switch address table: field widths, defaults,
// table entry type and controller/datapath command types. No dependencies.
package lsmt_pkg;

    localparam int ADDR_W            = 48;
    localparam int PORT_W            = 4;
    localparam int TIME_W            = 32;
    localparam int MASK_W            = 10;
    localparam int DEF_PORT_COUNT    = 10;
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam logic [TIME_W-1:0] AGING_RESET = 32'd1000000;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_we;   // write an empty entry at the index
        logic load;     // capture a new header and clear the sweep flags
        logic rd_en;    // read the entry at the index
        logic commit;   // learn the source and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // the result register can take a new result
    } t_status;

endpackage

/* rtl/core/learning_switch_mac_table_top.sv */
// Top level of the learning switch address table with aging.
// Depends on lsmt_pkg, lsmt_ctrl and lsmt_dp.
//
//   Channel   Direction  Handshake                    Payload
//   in        input      i_in_valid / o_in_stall      source, target, port, time
//   out       output     o_out_valid / i_out_stall    egress mask and three flags
//   cfg       input      i_cfg_we                     i_cfg_wdata (aging time)
//
// Each header is handled in steps: the transfer is taken, the single read
// port of the entry memory sweeps the table entry by entry, the last entry
// is finished, and the source is learned and the result posted. After reset
// a clearing pass empties the table, and no input is taken during it. A
// stalled result waits in the output register while the next header is
// already taken and swept; only the posting of the following result waits
// for the output register to free up.
module learning_switch_mac_table_top import lsmt_pkg::*; #(
    parameter int PORT_COUNT    = DEF_PORT_COUNT,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TIME_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ADDR_W-1:0] i_source_address,
    input  logic [ADDR_W-1:0] i_target_address,
    input  logic [PORT_W-1:0] i_arrival_port,
    input  logic [TIME_W-1:0] i_now_ticks,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_egress_mask,
    output logic              o_target_found,
    output logic              o_source_learned,
    output logic              o_learn_refused
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] idx;

    // The controller sequences the clearing pass and the per-header sweep.
    lsmt_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    // The datapath holds the table, ages and matches entries, and posts results.
    lsmt_dp #(
        .PORT_COUNT   (PORT_COUNT),
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (cmd),
        .i_idx            (idx),
        .o_status         (status),
        .i_source_address (i_source_address),
        .i_target_address (i_target_address),
        .i_arrival_port   (i_arrival_port),
        .i_now_ticks      (i_now_ticks),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_egress_mask    (o_egress_mask),
        .o_target_found   (o_target_found),
        .o_source_learned (o_source_learned),
        .o_learn_refused  (o_learn_refused)
    );

endmodule

/* rtl/core/lsmt_ctrl.sv */
// Controller of the learning switch address table: clearing pass, sweep and
// commit sequencing. Depends on lsmt_pkg.
module lsmt_ctrl import lsmt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_status          i_status,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_idx
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             last;

    assign last       = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign o_idx      = r_idx;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (last) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (last) begin
                    n_idx   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

/* rtl/core/lsmt_dp.sv */
// Datapath of the learning switch address table: entry memory, aging and
// match logic, learn write and result register. Depends on lsmt_pkg.
module lsmt_dp import lsmt_pkg::*; #(
    parameter int PORT_COUNT    = DEF_PORT_COUNT,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TIME_W-1:0] i_cfg_wdata,
    input  t_cmd              i_cmd,
    input  logic [IDX_W-1:0]  i_idx,
    output t_status           o_status,
    input  logic [ADDR_W-1:0] i_source_address,
    input  logic [ADDR_W-1:0] i_target_address,
    input  logic [PORT_W-1:0] i_arrival_port,
    input  logic [TIME_W-1:0] i_now_ticks,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_egress_mask,
    output logic              o_target_found,
    output logic              o_source_learned,
    output logic              o_learn_refused
);

    t_entry mem [TABLE_ENTRIES];

    logic [TIME_W-1:0] r_aging;
    logic [ADDR_W-1:0] r_src, r_dst;
    logic [PORT_W-1:0] r_port, r_dst_port;
    logic [TIME_W-1:0] r_now;
    t_entry            r_rd_data;
    logic [IDX_W-1:0]  r_eval_addr, r_free_idx;
    logic              r_eval_vld;
    logic              r_src_hit, r_dst_hit, r_free_ok;
    logic              r_ov;
    logic [MASK_W-1:0] r_mask;
    logic              r_found, r_learned, r_refused;

    logic [TIME_W-1:0] age;
    logic              expired, live;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    t_entry            wdata;
    logic              learn, found;
    logic [PORT_W-1:0] hit_port;
    logic [31:0]       all_v, hit_bit, arr_bit, mask_v;

    assign age     = r_now - r_rd_data.stamp;
    assign expired = r_rd_data.valid && (age > r_aging);
    assign live    = r_rd_data.valid && !expired;

    assign learn    = !r_src_hit && r_free_ok;
    assign found    = r_dst_hit || (learn && (r_dst == r_src));
    assign hit_port = r_dst_hit ? r_dst_port : r_port;

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            all_v[i] = (i < PORT_COUNT);
        end
        hit_bit = (32'(hit_port) < 32'(PORT_COUNT)) ? (32'd1 << hit_port) : '0;
        arr_bit = (32'(r_port) < 32'(PORT_COUNT)) ? (32'd1 << r_port) : '0;
        mask_v  = found ? hit_bit : (all_v & ~arr_bit);
    end

    // One write port: clearing pass, expiry, or learn; never two at once.
    always_comb begin
        we    = 1'b0;
        waddr = i_idx;
        wdata = '0;
        priority if (i_cmd.clr_we) begin
            we = 1'b1;
        end else if (r_eval_vld && expired) begin
            we          = 1'b1;
            waddr       = r_eval_addr;
            wdata       = r_rd_data;
            wdata.valid = 1'b0;
        end else if (i_cmd.commit && learn) begin
            we    = 1'b1;
            waddr = r_free_idx;
            wdata = '{valid: 1'b1, addr: r_src, port: r_port, stamp: r_now};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_addr <= i_idx;
        if (i_cmd.load) begin
            r_src     <= i_source_address;
            r_dst     <= i_target_address;
            r_port    <= i_arrival_port;
            r_now     <= i_now_ticks;
            r_src_hit <= 1'b0;
            r_dst_hit <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_eval_vld) begin
            if (live && (r_rd_data.addr == r_src)) begin
                r_src_hit <= 1'b1;
            end
            if (live && (r_rd_data.addr == r_dst) && !r_dst_hit) begin
                r_dst_hit  <= 1'b1;
                r_dst_port <= r_rd_data.port;
            end
            if (!live && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_eval_addr;
            end
        end
        if (i_cmd.commit) begin
            r_mask    <= mask_v[MASK_W-1:0];
            r_found   <= found;
            r_learned <= learn;
            r_refused <= !r_src_hit && !r_free_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging    <= AGING_RESET;
            r_eval_vld <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_aging <= i_cfg_wdata;
            end
            r_eval_vld <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_ov || !i_out_stall;
    assign o_out_valid       = r_ov;
    assign o_egress_mask     = r_mask;
    assign o_target_found    = r_found;
    assign o_source_learned  = r_learned;
    assign o_learn_refused   = r_refused;

endmodule

/* rtl/core/lsmt_checker.sv */
// Port-level checker of the learning switch address table and its binding.
// Depends on lsmt_pkg and learning_switch_mac_table_top_defines.svh.
`include "learning_switch_mac_table_top_defines.svh"

module lsmt_checker import lsmt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [MASK_W-1:0] o_egress_mask,
    input logic              o_source_learned,
    input logic              o_learn_refused
);

    `LSMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `LSMT_ASSERT_NEXT(a_mask_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_egress_mask))
    `LSMT_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `LSMT_ASSERT_IMPLY(a_flags_excl, i_clk, i_rst_n, o_out_valid, !(o_source_learned && o_learn_refused))

endmodule

bind learning_switch_mac_table_top lsmt_checker u_lsmt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_egress_mask    (o_egress_mask),
    .o_source_learned (o_source_learned),
    .o_learn_refused  (o_learn_refused)
);

/* tb/sv/tb.sv */
// Testbench for learning_switch_mac_table_top: drives frame headers, predicts the
// egress mask and learn flags with its own table model, and checks each result.
// Depends on lsmt_pkg and the RTL of learning_switch_mac_table_top.
module tb;
    import lsmt_pkg::*;

    localparam int NPORTS  = DEF_PORT_COUNT;
    localparam int NSLOTS  = DEF_TABLE_ENTRIES;
    // Longer than the sweep of one header, with a margin for draining.
    localparam int SETTLE  = NSLOTS + 20;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              found;
        logic              learned;
        logic              refused;
    } t_verdict;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [TIME_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [ADDR_W-1:0] i_source_address;
    logic [ADDR_W-1:0] i_target_address;
    logic [PORT_W-1:0] i_arrival_port;
    logic [TIME_W-1:0] i_now_ticks;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [MASK_W-1:0] o_egress_mask;
    logic              o_target_found;
    logic              o_source_learned;
    logic              o_learn_refused;

    learning_switch_mac_table_top u_top (.*);

    // The testbench's own copy of the forwarding table and the aging register.
    logic              fdb_valid [NSLOTS];
    logic [ADDR_W-1:0] fdb_addr  [NSLOTS];
    logic [PORT_W-1:0] fdb_port  [NSLOTS];
    logic [TIME_W-1:0] fdb_stamp [NSLOTS];
    logic [TIME_W-1:0] aging_limit;

    t_verdict   pending_verdicts[$];
    int         mismatches;
    int         verdicts_seen;
    bit         hold_receiver;
    logic [TIME_W-1:0] clock_ticks;
    logic [ADDR_W-1:0] known_macs[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mirrors one frame through the table: aging, learning, then lookup.
    function automatic t_verdict forward_frame(logic [ADDR_W-1:0] src,
                                               logic [ADDR_W-1:0] dst,
                                               logic [PORT_W-1:0] port,
                                               logic [TIME_W-1:0] now);
        t_verdict v;
        int hit;
        bit present;
        bit placed;
        logic [31:0] all_mask;
        v = '0;
        present = 1'b0;
        placed = 1'b0;
        hit = -1;
        for (int i = 0; i < NSLOTS; i++) begin
            if (fdb_valid[i] && (now - fdb_stamp[i]) > aging_limit)
                fdb_valid[i] = 1'b0;
        end
        for (int i = 0; i < NSLOTS; i++) begin
            if (fdb_valid[i] && fdb_addr[i] == src)
                present = 1'b1;
        end
        if (!present) begin
            for (int i = 0; i < NSLOTS && !placed; i++) begin
                if (!fdb_valid[i]) begin
                    fdb_valid[i] = 1'b1;
                    fdb_addr[i]  = src;
                    fdb_port[i]  = port;
                    fdb_stamp[i] = now;
                    placed = 1'b1;
                end
            end
            v.learned = placed;
            v.refused = !placed;
        end
        for (int i = NSLOTS - 1; i >= 0; i--) begin
            if (fdb_valid[i] && fdb_addr[i] == dst)
                hit = i;
        end
        all_mask = (32'd1 << NPORTS) - 1;
        if (hit >= 0) begin
            v.found = 1'b1;
            v.mask = (fdb_port[hit] < NPORTS) ? MASK_W'(32'd1 << fdb_port[hit]) : '0;
        end else begin
            v.mask = MASK_W'(all_mask & ~((port < NPORTS) ? (32'd1 << port) : 32'd0));
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    // Offers one header with a random gap first; returns after the transfer.
    task automatic send_frame(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                              logic [PORT_W-1:0] port, logic [TIME_W-1:0] now);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 150)
                                          : $urandom_range(1, 3);
        repeat (gap) @(negedge i_clk);
        i_source_address <= src;
        i_target_address <= dst;
        i_arrival_port   <= port;
        i_now_ticks      <= now;
        i_in_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_verdicts.push_back(forward_frame(src, dst, port, now));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Waits for every expected result, then lets the table sweep settle.
    task automatic drain_table();
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_aging(logic [TIME_W-1:0] ticks);
        drain_table();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        aging_limit = ticks;
    endtask

    function automatic logic [ADDR_W-1:0] pick_mac();
        if (known_macs.size() != 0 && $urandom_range(0, 2) != 0)
            return known_macs[$urandom_range(0, known_macs.size() - 1)];
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // Directed: extremes of the fields, source equals destination, and
    // out-of-range arrival ports both stored and used as flood origin.
    task automatic test_directed();
        send_frame('0, '1, 4'd0, 32'd0);
        send_frame('1, '0, 4'd9, 32'd1);
        send_frame(48'hAAAA_5555_AAAA, 48'hAAAA_5555_AAAA, 4'd3, 32'd2);
        send_frame(48'h5555_AAAA_5555, '1, 4'd15, 32'd3);
        send_frame(48'h0000_0000_0042, 48'h5555_AAAA_5555, 4'd1, 32'd4);
        send_frame(48'h0000_0000_0043, 48'h0000_0000_0042, 4'd10, 32'd5);
        send_frame(48'h0000_0000_0044, 48'h0000_0000_0043, 4'd12, 32'hFFFF_FFFF);
        // Time wrapping past zero still gives small ages and expires nothing.
        send_frame(48'h0000_0000_0045, 48'h0000_0000_0044, 4'd2, 32'd6);
        send_frame(48'h0000_0000_0046, '0, 4'd7, 32'h8000_0000);
    endtask

    // Fills the table past its capacity so later sources are refused.
    task automatic test_full_table();
        set_aging(32'hFFFF_FFFF);
        for (int i = 0; i < NSLOTS + 6; i++)
            send_frame(48'h0200_0000_0000 + i, 48'h0200_0000_0000 + (i ^ 3),
                       4'($urandom_range(0, 9)), clock_ticks + i);
        // Aging at zero expires everything with a nonzero age.
        set_aging(32'd0);
        send_frame(48'h0300_0000_0001, 48'h0200_0000_0001, 4'd4, clock_ticks + 500);
        send_frame(48'h0300_0000_0002, 48'h0300_0000_0001, 4'd5, clock_ticks + 500);
        clock_ticks += 501;
    endtask

    // Receiver holds off for a long stretch while headers keep coming.
    task automatic test_backpressure();
        set_aging(32'd1000);
        hold_receiver = 1'b1;
        fork
            begin
                repeat (600) @(negedge i_clk);
                hold_receiver = 1'b0;
            end
            for (int i = 0; i < 8; i++) begin
                clock_ticks += $urandom_range(0, 50);
                send_frame(pick_mac(), pick_mac(), 4'($urandom_range(0, 9)), clock_ticks);
            end
        join
    endtask

    // Random traffic from a small MAC population so lookups hit and entries age.
    task automatic test_random_traffic();
        logic [TIME_W-1:0] limits[4];
        limits = '{32'd200, 32'd3000, AGING_RESET, 32'hFFFF_FFFF};
        for (int phase = 0; phase < 4; phase++) begin
            set_aging(limits[phase]);
            for (int i = 0; i < 250; i++) begin
                if (known_macs.size() < 90 && $urandom_range(0, 3) == 0)
                    known_macs.push_back(ADDR_W'({$urandom, $urandom}));
                clock_ticks += ($urandom_range(0, 15) == 0) ? $urandom
                                                            : $urandom_range(0, 40);
                send_frame(pick_mac(), pick_mac(), 4'($urandom_range(0, 15)),
                           clock_ticks);
            end
        end
    endtask

    // Result checker: compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                t_verdict want;
                want = pending_verdicts.pop_front();
                if (o_egress_mask !== want.mask)
                    report_mismatch("egress_mask", 32'(o_egress_mask), 32'(want.mask));
                if (o_target_found !== want.found)
                    report_mismatch("target_found", 32'(o_target_found), 32'(want.found));
                if (o_source_learned !== want.learned)
                    report_mismatch("source_learned", 32'(o_source_learned),
                                    32'(want.learned));
                if (o_learn_refused !== want.refused)
                    report_mismatch("learn_refused", 32'(o_learn_refused),
                                    32'(want.refused));
            end
            verdicts_seen++;
        end
    end

    // Receiver stall: mostly short, sometimes long, forced high while held.
    initial begin
        int run;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                i_out_stall <= 1'b1;
            end else if (run > 0) begin
                run--;
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(0, 3);
            end
        end
    end

    initial begin
        #30_000_000;
        $display("learning_switch_mac_table_top verification failed");
        $finish;
    end

    initial begin
        mismatches = 0;
        verdicts_seen = 0;
        hold_receiver = 1'b0;
        clock_ticks = 32'd1000;
        aging_limit = AGING_RESET;
        for (int i = 0; i < NSLOTS; i++) fdb_valid[i] = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_source_address = '0;
        i_target_address = '0;
        i_arrival_port = '0;
        i_now_ticks = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random_traffic();
        drain_table();
        if (mismatches == 0)
            $display("learning_switch_mac_table_top verification clean");
        else
            $display("learning_switch_mac_table_top verification failed");
        $finish;
    end
endmodule
